[design/ple_pkg.sv]
// shared types and codes for the positional list engine
// holds status, mode and cell operation codes plus the cell control word
// no dependencies
package ple_pkg;

   // default list depth
   localparam int CAPACITY_DEF = 16;

   // width of positions and counts (list holds at most 127 entries)
   localparam int POS_W = 7;
   localparam int DATA_W = 32;

   // operation modes of a request word
   localparam logic [1:0] MODE_INSERT   = 2'd0;
   localparam logic [1:0] MODE_DELETE   = 2'd1;
   localparam logic [1:0] MODE_SEARCH   = 2'd2;
   localparam logic [1:0] MODE_TRAVERSE = 2'd3;

   // status codes of a response word
   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_FULL     = 3'd1;
   localparam logic [2:0] STAT_BADPOS   = 3'd2;
   localparam logic [2:0] STAT_EMPTY    = 3'd3;
   localparam logic [2:0] STAT_NOTFOUND = 3'd4;

   // cell operations
   localparam logic [2:0] CELL_HOLD   = 3'd0;
   localparam logic [2:0] CELL_INSERT = 3'd1;
   localparam logic [2:0] CELL_DELETE = 3'd2;
   localparam logic [2:0] CELL_ROTATE = 3'd3;
   localparam logic [2:0] CELL_MATCH  = 3'd4;

   // control word broadcast to every cell
   typedef struct packed {
      logic [2:0]              op;
      logic [POS_W-1:0]        slot;
      logic signed [DATA_W-1:0] data;
   } cell_ctl_type;

endpackage

[design/ple_cell.sv]
// one storage cell of the list chain
// holds one entry and a match flag, trades entries with its neighbors
// depends on ple_pkg
module ple_cell #(
   parameter int INDEX = 0
) (
   input  logic                              clock,
   input  ple_pkg::cell_ctl_type             ctl,
   input  logic signed [ple_pkg::DATA_W-1:0] left_value,
   input  logic signed [ple_pkg::DATA_W-1:0] right_value,
   input  logic signed [ple_pkg::DATA_W-1:0] head_value,
   output logic signed [ple_pkg::DATA_W-1:0] value,
   output logic                              match
);
   import ple_pkg::*;

   localparam logic [POS_W-1:0] MY_SLOT = POS_W'(INDEX);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic                     match_ff;
   logic                     match_in;

   // next entry from the broadcast operation
   always_comb begin
      value_in = value_ff;
      match_in = match_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (MY_SLOT > ctl.slot) begin
               value_in = left_value;
            end else if (MY_SLOT == ctl.slot) begin
               value_in = ctl.data;
            end
         end
         CELL_DELETE: begin
            if (MY_SLOT >= ctl.slot) begin
               value_in = right_value;
            end
         end
         CELL_ROTATE: begin
            if (MY_SLOT == ctl.slot) begin
               value_in = head_value;
            end else if (MY_SLOT < ctl.slot) begin
               value_in = right_value;
            end
         end
         CELL_MATCH: begin
            match_in = (value_ff == ctl.data);
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // entry storage
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      match_ff <= match_in;
   end

   assign value = value_ff;
   assign match = match_ff;

endmodule

[design/positional_list_engine.sv]
// positional list engine: insert, delete and search take one request word each;
// insert and delete accept the next word in the following cycle,
// search holds busy while the match flags are priority encoded,
// traverse holds busy while the cell chain rotates once.
// results cannot be stalled; synchronous reset empties the list (entries undefined)
// depends on ple_pkg and ple_cell
module positional_list_engine #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_mode,
   input  logic signed [ple_pkg::DATA_W-1:0] req_value,
   input  logic [7:0]                        req_position,
   output logic                              rsp_strobe,
   output logic [2:0]                        rsp_status,
   output logic signed [ple_pkg::DATA_W-1:0] rsp_item_value,
   output logic [ple_pkg::POS_W-1:0]         rsp_item_position,
   output logic                              rsp_last
);
   import ple_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_TRAV   = 2'd2;

   localparam logic [POS_W-1:0] CAP_P = POS_W'(CAPACITY);

   logic [1:0]       state_ff, state_in;
   logic [POS_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] tcnt_ff, tcnt_in;

   logic                     strobe_ff, strobe_in;
   logic [2:0]               status_ff, status_in;
   logic signed [DATA_W-1:0] ivalue_ff, ivalue_in;
   logic [POS_W-1:0]         ipos_ff, ipos_in;
   logic                     last_ff, last_in;

   cell_ctl_type ctl;
   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]      cell_match;

   logic             accept;
   logic             found;
   logic [POS_W-1:0] found_pos;
   logic [7:0]       count_ext;
   logic [POS_W-1:0] slot_req;

   assign accept    = start && (state_ff == S_IDLE);
   assign count_ext = {1'b0, count_ff};
   assign slot_req  = POS_W'(req_position - 8'd1);

   // first live cell that matched, lowest position wins
   always_comb begin
      found     = 1'b0;
      found_pos = '0;
      for (int k = CAPACITY - 1; k >= 0; k--) begin
         if (cell_match[k] && (POS_W'(k) < count_ff)) begin
            found     = 1'b1;
            found_pos = POS_W'(k + 1);
         end
      end
   end

   // sequencer, cell control and response word
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      tcnt_in   = tcnt_ff;
      strobe_in = 1'b0;
      status_in = STAT_OK;
      ivalue_in = '0;
      ipos_in   = '0;
      last_in   = 1'b1;
      ctl.op    = CELL_HOLD;
      ctl.slot  = '0;
      ctl.data  = req_value;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_INSERT: begin
                     strobe_in = 1'b1;
                     if (count_ff >= CAP_P) begin
                        status_in = STAT_FULL;
                     end else if (count_ff == '0) begin
                        ctl.op   = CELL_INSERT;
                        ctl.slot = '0;
                        count_in = POS_W'(1);
                     end else if (req_position == 8'd0 ||
                                  req_position > count_ext + 8'd1) begin
                        status_in = STAT_BADPOS;
                     end else begin
                        ctl.op   = CELL_INSERT;
                        ctl.slot = slot_req;
                        count_in = count_ff + POS_W'(1);
                     end
                  end
                  MODE_DELETE: begin
                     strobe_in = 1'b1;
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else if (req_position == 8'd0 || req_position > count_ext) begin
                        status_in = STAT_BADPOS;
                     end else begin
                        ctl.op   = CELL_DELETE;
                        ctl.slot = slot_req;
                        count_in = count_ff - POS_W'(1);
                     end
                  end
                  MODE_SEARCH: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        status_in = STAT_EMPTY;
                     end else begin
                        ctl.op   = CELL_MATCH;
                        state_in = S_SEARCH;
                     end
                  end
                  MODE_TRAVERSE: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        status_in = STAT_EMPTY;
                     end else begin
                        tcnt_in  = '0;
                        state_in = S_TRAV;
                     end
                  end
                  default: begin
                     strobe_in = 1'b0;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            strobe_in = 1'b1;
            state_in  = S_IDLE;
            if (found) begin
               ipos_in = found_pos;
            end else begin
               status_in = STAT_NOTFOUND;
            end
         end
         S_TRAV: begin
            // head cell goes out, chain rotates by one
            strobe_in = 1'b1;
            ivalue_in = cell_value[0];
            ipos_in   = tcnt_ff + POS_W'(1);
            last_in   = (tcnt_ff + POS_W'(1) == count_ff);
            ctl.op    = CELL_ROTATE;
            ctl.slot  = count_ff - POS_W'(1);
            tcnt_in   = tcnt_ff + POS_W'(1);
            if (last_in) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // response payload and traverse counter
   always_ff @(posedge clock) begin
      tcnt_ff   <= tcnt_in;
      status_ff <= status_in;
      ivalue_ff <= ivalue_in;
      ipos_ff   <= ipos_in;
      last_ff   <= last_in;
   end

   // cell chain
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic signed [DATA_W-1:0] left_v;
      logic signed [DATA_W-1:0] right_v;
      if (k == 0) begin : g_first
         assign left_v = cell_value[0];
      end else begin : g_left
         assign left_v = cell_value[k-1];
      end
      if (k == CAPACITY - 1) begin : g_end
         assign right_v = cell_value[CAPACITY-1];
      end else begin : g_right
         assign right_v = cell_value[k+1];
      end
      ple_cell #(
         .INDEX(k)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .left_value  (left_v),
         .right_value (right_v),
         .head_value  (cell_value[0]),
         .value       (cell_value[k]),
         .match       (cell_match[k])
      );
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_item_value    = ivalue_ff;
   assign rsp_item_position = ipos_ff;
   assign rsp_last          = last_ff;

endmodule

[verif/positional_list_engine_tb.sv]
// testbench for positional_list_engine: directed list edits then weighted random operations
// keeps its own copy of the list, predicts every response word and checks them in order
// depends on design/ple_pkg.sv and design/positional_list_engine.sv
module positional_list_engine_tb;
   import ple_pkg::*;

   localparam int CAPACITY = CAPACITY_DEF;

   // one expected response word
   typedef struct {
      logic [2:0]               status;
      logic signed [DATA_W-1:0] item_value;
      logic [POS_W-1:0]         item_position;
      logic                     last;
   } list_rsp_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [1:0]               req_mode;
   logic signed [DATA_W-1:0] req_value;
   logic [7:0]               req_position;
   logic                     rsp_strobe;
   logic [2:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_item_value;
   logic [POS_W-1:0]         rsp_item_position;
   logic                     rsp_last;

   // shadow list and expected words
   logic signed [DATA_W-1:0] list_store [CAPACITY];
   int                       entry_count;
   list_rsp_type             pending_rsp [$];

   // run bookkeeping
   int  mismatch_count;
   int  words_checked;
   int  ops_by_mode [4];
   int  full_rejects;
   int  peak_count;
   int  drain_guard;
   bit  idle_on;

   positional_list_engine #(.CAPACITY(CAPACITY)) u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_item_value    (rsp_item_value),
      .rsp_item_position (rsp_item_position),
      .rsp_last          (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 30) $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // apply one accepted operation to the shadow list and queue its words
   task automatic predict_op(input logic [1:0] mode, input logic signed [DATA_W-1:0] value,
                             input logic [7:0] position);
      list_rsp_type w;
      int           p;
      int           k;
      bit           hit;
      p = int'(position);
      hit = 1'b0;
      w.status = STAT_OK;
      w.item_value = '0;
      w.item_position = '0;
      w.last = 1'b1;
      ops_by_mode[mode]++;
      case (mode)
         MODE_INSERT: begin
            // full check wins over every other insert check
            if (entry_count >= CAPACITY) begin
               w.status = STAT_FULL;
               full_rejects++;
            end else if (entry_count == 0) begin
               list_store[0] = value;
               entry_count = 1;
            end else if (p < 1 || p > entry_count + 1) begin
               w.status = STAT_BADPOS;
            end else begin
               for (k = entry_count; k >= p; k--) list_store[k] = list_store[k-1];
               list_store[p-1] = value;
               entry_count++;
            end
            pending_rsp.push_back(w);
         end
         MODE_DELETE: begin
            if (entry_count == 0) begin
               w.status = STAT_EMPTY;
            end else if (p < 1 || p > entry_count) begin
               w.status = STAT_BADPOS;
            end else begin
               for (k = p - 1; k + 1 < entry_count; k++) list_store[k] = list_store[k+1];
               entry_count--;
            end
            pending_rsp.push_back(w);
         end
         MODE_SEARCH: begin
            if (entry_count == 0) begin
               w.status = STAT_EMPTY;
            end else begin
               // first matching position wins
               for (k = 0; k < entry_count && !hit; k++) begin
                  if (list_store[k] == value) begin
                     hit = 1'b1;
                     w.item_position = POS_W'(k + 1);
                  end
               end
               if (!hit) w.status = STAT_NOTFOUND;
            end
            pending_rsp.push_back(w);
         end
         default: begin
            if (entry_count == 0) begin
               w.status = STAT_EMPTY;
               pending_rsp.push_back(w);
            end else begin
               for (k = 0; k < entry_count; k++) begin
                  w.item_value = list_store[k];
                  w.item_position = POS_W'(k + 1);
                  w.last = (k + 1 == entry_count);
                  pending_rsp.push_back(w);
               end
            end
         end
      endcase
      if (entry_count > peak_count) peak_count = entry_count;
   endtask

   // drive one request word, hold it until accepted, then maybe idle
   task automatic send_op(input logic [1:0] mode, input logic signed [DATA_W-1:0] value,
                          input logic [7:0] position);
      int gap;
      int r;
      start <= 1'b1;
      req_mode <= mode;
      req_value <= value;
      req_position <= position;
      do @(posedge clock); while (busy);
      predict_op(mode, value, position);
      gap = 0;
      if (idle_on) begin
         r = $urandom_range(0, 99);
         if (r >= 90) gap = $urandom_range(8, 30);
         else if (r >= 60) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // operations on an empty or single-entry list
   task automatic test_empty_list();
      send_op(MODE_DELETE, 0, 1);
      send_op(MODE_SEARCH, 0, 0);
      send_op(MODE_TRAVERSE, 0, 0);
      // empty list stores at the head whatever the position says
      send_op(MODE_INSERT, 32'sh7FFF_FFFF, 0);
      send_op(MODE_DELETE, 0, 0);
      send_op(MODE_DELETE, 0, 2);
      send_op(MODE_DELETE, 0, 1);
      send_op(MODE_INSERT, 32'sh8000_0000, 255);
   endtask

   // head, tail and out-of-range edits, duplicate search
   task automatic test_edit_positions();
      send_op(MODE_INSERT, 0, 0);
      send_op(MODE_INSERT, 0, 3);
      send_op(MODE_INSERT, 0, 255);
      send_op(MODE_INSERT, -1, 1);
      send_op(MODE_INSERT, 32'sh7FFF_FFFF, 3);
      send_op(MODE_INSERT, -1, 2);
      send_op(MODE_SEARCH, -1, 0);
      send_op(MODE_SEARCH, 12345, 0);
      send_op(MODE_SEARCH, 32'sh7FFF_FFFF, 0);
      send_op(MODE_TRAVERSE, 0, 0);
      send_op(MODE_DELETE, 0, 4);
      send_op(MODE_DELETE, 0, 1);
      send_op(MODE_TRAVERSE, 0, 0);
   endtask

   // fill to capacity, then hit the full and range checks
   task automatic test_full_list();
      while (entry_count < CAPACITY)
         send_op(MODE_INSERT, $urandom, 8'($urandom_range(1, entry_count + 1)));
      send_op(MODE_INSERT, 7, 0);
      send_op(MODE_INSERT, 7, 1);
      send_op(MODE_TRAVERSE, 0, 0);
      send_op(MODE_DELETE, 0, 8'(CAPACITY + 1));
      send_op(MODE_SEARCH, list_store[CAPACITY-1], 0);
   endtask

   // weighted random operations; ins_w and del_w are percentages
   task automatic test_random_ops(input int n, input int ins_w, input int del_w);
      int                       i;
      int                       r;
      int                       q;
      logic [1:0]               mode;
      logic signed [DATA_W-1:0] value;
      logic [7:0]               position;
      for (i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         q = $urandom_range(0, 99);
         if (r < ins_w) mode = MODE_INSERT;
         else if (r < ins_w + del_w) mode = MODE_DELETE;
         else if (r < ins_w + del_w + (100 - ins_w - del_w) * 2 / 3) mode = MODE_SEARCH;
         else mode = MODE_TRAVERSE;
         // values: small pool for repeats, extremes, or any 32-bit pattern
         if (mode == MODE_SEARCH && entry_count > 0 && q < 60)
            value = list_store[$urandom_range(0, entry_count - 1)];
         else if (q < 75) value = int'($urandom_range(0, 15)) - 8;
         else if (q < 82) value = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         else value = $urandom;
         // positions: mostly legal, some zero, some anywhere in range
         r = $urandom_range(0, 99);
         if (mode == MODE_INSERT && r < 80) position = 8'($urandom_range(1, entry_count + 1));
         else if (mode == MODE_DELETE && entry_count > 0 && r < 80)
            position = 8'($urandom_range(1, entry_count));
         else if (r < 88) position = 0;
         else position = 8'($urandom_range(0, 255));
         send_op(mode, value, position);
      end
   endtask

   // check each response word against the oldest expectation
   always @(posedge clock) begin : rsp_check
      list_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected word status %0d value %0d pos %0d last %0b",
                                      rsp_status, rsp_item_value, rsp_item_position, rsp_last));
         end else begin
            want = pending_rsp.pop_front();
            words_checked++;
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_item_value !== want.item_value)
               report_mismatch($sformatf("item_value %0d, want %0d",
                                         rsp_item_value, want.item_value));
            if (rsp_item_position !== want.item_position)
               report_mismatch($sformatf("item_position %0d, want %0d",
                                         rsp_item_position, want.item_position));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0b, want %0b", rsp_last, want.last));
         end
      end
   end

   // run limit
   initial begin
      #5_000_000;
      $display("timeout with %0d words outstanding", pending_rsp.size());
      $display("positional_list_engine verification failed");
      $finish;
   end

   // reset, stimulus, drain, verdict
   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_mode = MODE_INSERT;
      req_value = '0;
      req_position = '0;
      entry_count = 0;
      mismatch_count = 0;
      words_checked = 0;
      full_rejects = 0;
      peak_count = 0;
      idle_on = 1'b1;
      foreach (ops_by_mode[m]) ops_by_mode[m] = 0;
      foreach (list_store[k]) list_store[k] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_edit_positions();
      test_full_list();
      test_random_ops(50, 15, 65);
      test_random_ops(50, 70, 15);
      idle_on = 1'b0;
      test_random_ops(40, 40, 30);
      idle_on = 1'b1;
      test_random_ops(35, 15, 70);
      test_random_ops(35, 35, 30);

      start <= 1'b0;
      drain_guard = 0;
      while (pending_rsp.size() > 0 && drain_guard < 2000) begin
         @(posedge clock);
         drain_guard++;
      end
      if (pending_rsp.size() > 0) begin
         $display("%0d words never arrived", pending_rsp.size());
         $display("positional_list_engine verification failed");
         $finish;
      end else begin
         // room for a stray word after the last expected one
         repeat (2 * CAPACITY + 4) @(posedge clock);
         $display("ran %0d ops: %0d insert, %0d delete, %0d search, %0d traverse",
                  ops_by_mode[MODE_INSERT] + ops_by_mode[MODE_DELETE]
                  + ops_by_mode[MODE_SEARCH] + ops_by_mode[MODE_TRAVERSE],
                  ops_by_mode[MODE_INSERT], ops_by_mode[MODE_DELETE],
                  ops_by_mode[MODE_SEARCH], ops_by_mode[MODE_TRAVERSE]);
         $display("%0d words checked, peak depth %0d of %0d, %0d full rejects, %0d mismatches",
                  words_checked, peak_count, CAPACITY, full_rejects, mismatch_count);
         if (mismatch_count == 0)
            $display("positional_list_engine verification clean");
         else
            $display("positional_list_engine verification failed");
         $finish;
      end
   end

endmodule

[files.f]
design/ple_pkg.sv
design/ple_cell.sv
design/positional_list_engine.sv
verif/positional_list_engine_tb.sv
